>>> rtl/isw_pkg.sv
// ----------------------------------------------------------------------------
// isw_pkg
// Shared types and constants for the IMU sample window averager.
// ----------------------------------------------------------------------------
package isw_pkg;

    localparam int unsigned CH_W      = 17;
    localparam int unsigned SUM_W     = 24;
    localparam int unsigned NUM_CH    = 7;
    localparam int unsigned CFG_AW    = 5;
    localparam int unsigned CFG_DW    = 64;
    localparam logic [CH_W-1:0] TEMP_OFFSET = 17'sd440;

    localparam logic [CFG_AW-1:0] ADDR_INTERVAL = 5'd0;
    localparam logic [CFG_AW-1:0] ADDR_WINDOW   = 5'd8;
    localparam logic [CFG_AW-1:0] ADDR_AVG_MODE = 5'd16;
    localparam logic [CFG_AW-1:0] ADDR_START    = 5'd24;

    typedef logic signed [CH_W-1:0]  t_ch;
    typedef logic signed [SUM_W-1:0] t_sum;

    // Divider request/response
    typedef struct packed {
        logic       start;
        t_sum       dividend;
        logic [6:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
        t_ch  quotient;
    } t_div_rsp;

endpackage

>>> rtl/isw_if.sv
// ----------------------------------------------------------------------------
// isw_if
// Valid/ready stream interface carrying a packed payload.
// ----------------------------------------------------------------------------
interface isw_if #(
    parameter int unsigned W = 8
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/isw_div.sv
// ----------------------------------------------------------------------------
// isw_div
// Restoring signed divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module isw_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  isw_pkg::t_div_req   i_req,
    output isw_pkg::t_div_rsp   o_rsp
);
    localparam int unsigned SW = isw_pkg::SUM_W;

    logic [SW-1:0] r_rem;
    logic [SW-1:0] r_quo;
    logic [6:0]    r_den;
    logic          r_neg;
    logic [4:0]    r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [SW:0]   w_trial;
    logic [SW-1:0] w_abs;
    logic [SW-1:0] w_q;

    assign w_abs   = i_req.dividend[SW-1] ? (~i_req.dividend + 1'b1) : i_req.dividend;
    assign w_trial = {r_rem, r_quo[SW-1]} - {{(SW-6){1'b0}}, r_den};
    assign w_q     = r_neg ? (~r_quo + 1'b1) : r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem  <= '0;
                r_quo  <= w_abs;
                r_den  <= i_req.divisor;
                r_neg  <= i_req.dividend[SW-1];
                r_cnt  <= 5'(SW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!w_trial[SW]) begin
                    r_rem <= w_trial[SW-1:0];
                    r_quo <= {r_quo[SW-2:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[SW-2:0], r_quo[SW-1]};
                    r_quo <= {r_quo[SW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = w_q[isw_pkg::CH_W-1:0];
endmodule

>>> rtl/imu_sample_window_averager.sv
// ----------------------------------------------------------------------------
// imu_sample_window_averager
// Buffers good IMU samples and flushes them, averaged or as a burst.
// ----------------------------------------------------------------------------
// channel  dir  beat
// s_in     in   read_ok, 7 raw channels, time_ms
// m_out    out  7 channels, time, sample count, last_in_burst
// cfg      in   APB writes/reads of interval, window, mode, start time
//
// A sample is absorbed through S_IDLE and S_CHECK; a burst flush emits each beat
// through S_RD and S_EMIT, and average mode runs 7 serial divides, one per channel,
// on the shared divider before a single averaged beat is emitted.
// Reset is synchronous; the sample memory is not cleared.
// s_in is not ready while a flush runs or a result beat waits.
// ----------------------------------------------------------------------------
module imu_sample_window_averager #(
    parameter int unsigned MAX_SAMPLES = 64,
    parameter int unsigned TIME_BITS   = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    isw_if.sink         s_in,
    isw_if.source       m_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [isw_pkg::CFG_AW-1:0] paddr,
    input  logic [isw_pkg::CFG_DW-1:0] pwdata,
    output logic [isw_pkg::CFG_DW-1:0] prdata,
    output logic        pready
);
    localparam int unsigned AW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int unsigned CW  = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned CHW = isw_pkg::CH_W;
    localparam int unsigned SMW = 7 * CHW + TIME_BITS;

    typedef enum logic [2:0] {S_IDLE, S_CHECK, S_RD, S_EMIT, S_DIV, S_DWAIT, S_AOUT}
        t_state;

    // Input payload fields
    logic        w_ok;
    logic signed [15:0] w_raw [7];
    logic [47:0] w_time_in;
    assign w_ok      = s_in.data[160];
    assign w_raw[0]  = s_in.data[159:144];
    assign w_raw[1]  = s_in.data[143:128];
    assign w_raw[2]  = s_in.data[127:112];
    assign w_raw[3]  = s_in.data[111:96];
    assign w_raw[4]  = s_in.data[95:80];
    assign w_raw[5]  = s_in.data[79:64];
    assign w_raw[6]  = s_in.data[63:48];
    assign w_time_in = s_in.data[47:0];

    // Config
    logic [15:0]          r_interval;
    logic [6:0]           r_window;
    logic                 r_avg;
    logic [47:0]          r_start;
    logic [TIME_BITS-1:0] r_deadline;

    t_state               r_state;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_idx;
    logic [2:0]           r_ch;
    isw_pkg::t_sum        r_sum [7];
    isw_pkg::t_ch         r_avg_q [7];
    logic [TIME_BITS-1:0] r_last_t;
    logic [SMW-1:0]       r_mem [MAX_SAMPLES];
    logic [SMW-1:0]       r_rd;
    logic                 r_ovalid;
    logic [SMW+7:0]       r_odata;
    logic [CW-1:0]        w_eff;
    isw_pkg::t_ch         w_ch [7];
    logic [SMW-1:0]       w_wr;
    logic [TIME_BITS-1:0] w_t;
    logic [15+CW:0]       w_prod;
    logic [TIME_BITS-1:0] w_step;
    isw_pkg::t_div_req    w_dreq;
    isw_pkg::t_div_rsp    w_drsp;
    logic                 w_cfg_wr;

    assign w_cfg_wr = psel && penable && pwrite;
    assign pready   = 1'b1;

    always_comb begin
        unique case (paddr)
            isw_pkg::ADDR_INTERVAL: prdata = {48'd0, r_interval};
            isw_pkg::ADDR_WINDOW:   prdata = {57'd0, r_window};
            isw_pkg::ADDR_AVG_MODE: prdata = {63'd0, r_avg};
            isw_pkg::ADDR_START:    prdata = {16'd0, r_start};
            default:                prdata = '0;
        endcase
    end

    always_comb begin
        if (r_window == 7'd0) begin
            w_eff = CW'(1);
        end else if (32'(r_window) > MAX_SAMPLES) begin
            w_eff = CW'(MAX_SAMPLES);
        end else begin
            w_eff = CW'(r_window);
        end
    end

    assign w_t    = TIME_BITS'(w_time_in);
    assign w_prod = r_interval * w_eff;
    assign w_step = TIME_BITS'(w_prod);

    always_comb begin
        w_ch[0] = CHW'(w_raw[0]);
        w_ch[1] = -CHW'(w_raw[1]);
        w_ch[2] = CHW'(w_raw[2]);
        w_ch[3] = CHW'(w_raw[3]);
        w_ch[4] = -CHW'(w_raw[4]);
        w_ch[5] = CHW'(w_raw[5]);
        w_ch[6] = CHW'(w_raw[6]) + isw_pkg::TEMP_OFFSET;
        w_wr = {w_ch[0], w_ch[1], w_ch[2], w_ch[3], w_ch[4], w_ch[5], w_ch[6], w_t};
    end

    assign w_dreq.start    = (r_state == S_DIV);
    assign w_dreq.dividend = r_sum[r_ch];
    assign w_dreq.divisor  = 7'(r_count);

    isw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_rsp   (w_drsp)
    );

    always_ff @(posedge i_clk) begin
        if (s_in.valid && s_in.ready && w_ok && r_count < w_eff) begin
            r_mem[r_count[AW-1:0]] <= w_wr;
        end
        r_rd <= r_mem[r_idx[AW-1:0]];
    end

    assign s_in.ready  = (r_state == S_IDLE) && !r_ovalid;
    assign m_out.valid = r_ovalid;
    assign m_out.data  = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= 16'd10;
            r_window   <= 7'd10;
            r_avg      <= 1'b1;
            r_start    <= '0;
            r_deadline <= '0;
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_idx      <= '0;
            r_ch       <= '0;
            r_ovalid   <= 1'b0;
            for (int i = 0; i < 7; i++) r_sum[i] <= '0;
        end else begin
            if (m_out.valid && m_out.ready) r_ovalid <= 1'b0;
            if (w_cfg_wr) begin
                unique case (paddr)
                    isw_pkg::ADDR_INTERVAL: r_interval <= pwdata[15:0];
                    isw_pkg::ADDR_WINDOW:   r_window   <= pwdata[6:0];
                    isw_pkg::ADDR_AVG_MODE: r_avg      <= pwdata[0];
                    isw_pkg::ADDR_START: begin
                        r_start    <= pwdata[47:0];
                        r_deadline <= TIME_BITS'(pwdata[47:0]);
                    end
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_in.valid && s_in.ready) begin
                        r_last_t <= w_t;
                        if (!w_ok) begin
                            r_count <= '0;
                            for (int i = 0; i < 7; i++) r_sum[i] <= '0;
                        end else if (r_count < w_eff) begin
                            r_count <= r_count + 1'b1;
                            for (int i = 0; i < 7; i++)
                                r_sum[i] <= r_sum[i] + isw_pkg::SUM_W'(w_ch[i]);
                        end
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_count >= w_eff || r_last_t > r_deadline) begin
                        r_deadline <= r_deadline + w_step;
                        r_idx <= '0;
                        r_ch  <= '0;
                        if (r_count == '0) begin
                            r_state <= S_IDLE;
                        end else if (r_avg) begin
                            r_idx   <= r_count - 1'b1;
                            r_state <= S_DIV;
                        end else begin
                            r_state <= S_RD;
                        end
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_RD: begin
                    if (!r_ovalid) r_state <= S_EMIT;
                end
                S_EMIT: begin
                    r_odata <= {r_rd, 7'(r_count), (r_idx + 1'b1 == r_count)};
                    r_ovalid <= 1'b1;
                    r_idx <= r_idx + 1'b1;
                    if (r_idx + 1'b1 == r_count) begin
                        r_count <= '0;
                        for (int i = 0; i < 7; i++) r_sum[i] <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_DIV: r_state <= S_DWAIT;
                S_DWAIT: begin
                    if (w_drsp.done) begin
                        r_avg_q[r_ch] <= w_drsp.quotient;
                        if (r_ch == 3'd6) begin
                            r_state <= S_AOUT;
                        end else begin
                            r_ch    <= r_ch + 1'b1;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_AOUT: begin
                    if (!r_ovalid) begin
                        r_odata <= {r_avg_q[0], r_avg_q[1], r_avg_q[2], r_avg_q[3],
                                    r_avg_q[4], r_avg_q[5], r_avg_q[6],
                                    r_rd[TIME_BITS-1:0], 7'(r_count), 1'b1};
                        r_ovalid <= 1'b1;
                        r_count <= '0;
                        for (int i = 0; i < 7; i++) r_sum[i] <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
